// ===== sv/vadpcm_frame_decoder_top_assert.svh =====
// Assertion macros for the VADPCM frame decoder.
// Used by the controller and datapath; expects clk_i and rst_ni in scope.
`ifndef VADPCM_FRAME_DECODER_TOP_ASSERT_SVH
`define VADPCM_FRAME_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define VFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define VFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define VFD_ASSERT(label, prop, msg)
`define VFD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== sv/vfd_pkg.sv =====
// Shared types and constants for the VADPCM frame decoder.
// No dependencies; used by the controller, datapath and top level.
package vfd_pkg;

  localparam int TAPS      = 16;  // coefficient words per predictor
  localparam int HALF_LEN  = 8;   // samples per half frame
  localparam int FRAC_BITS = 11;

  typedef enum logic [1:0] {
    OP_BOOK_WR  = 2'd0,
    OP_HIST_SET = 2'd1,
    OP_DECODE   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_EMIT
  } state_e;

  // Second multiplier operand
  typedef enum logic [1:0] {
    OPND_OLD,
    OPND_NEW,
    OPND_RES
  } opnd_e;

  typedef struct packed {
    logic       book_wr;
    logic       hist_set;
    logic       frame_cap;
    logic       rd_en;
    logic [3:0] rd_tap;
    logic       coef_wr;
    logic [3:0] coef_wr_idx;
    logic       mac_en;
    logic       acc_first;
    opnd_e      opnd;
    logic [3:0] coef_idx;
    logic [3:0] res_idx;
    logic       emit;
    logic       last;
    logic       save_s6;
    logic       hist_upd;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== sv/vfd_if.sv =====
// Handshake interfaces for the decoder's request and sample channels.
// Depends on nothing; fields follow the decoder's request and sample layout.
interface vfd_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  opcode;
  logic        [7:0]  book_address;
  logic signed [15:0] book_value;
  logic signed [15:0] history_older;
  logic signed [15:0] history_newer;
  logic        [3:0]  scale;
  logic        [3:0]  predictor_select;
  logic        [63:0] frame_data;

  modport source (
    output valid, opcode, book_address, book_value, history_older, history_newer,
           scale, predictor_select, frame_data,
    input  ready
  );
  modport sink (
    input  valid, opcode, book_address, book_value, history_older, history_newer,
           scale, predictor_select, frame_data,
    output ready
  );
endinterface

interface vfd_smp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;

  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

// ===== sv/vadpcm_frame_decoder_top.sv =====
// Top level of the VADPCM frame decoder: controller plus datapath.
// Depends on vfd_pkg, vfd_if, vfd_ctrl and vfd_datapath.
//
//   port    dir   modport  carries
//   req_i   in    sink     opcode, codebook word, history, frame header and data
//   smp_o   out   source   one PCM sample and the end-of-frame flag
//
// Codebook write and set history complete on acceptance and leave the block idle.
// A decode is accepted, fetches the codebook words of the selected predictor (one read
// port), then runs the multiply-accumulate steps of each sample of each half on one
// shared 16x16 multiplier and emits the sample.
// A stalled sample holds in the output register; the next waits in its last step.
// Reset clears the history to zero; the codebook is undefined until written.
module vadpcm_frame_decoder_top #(
  parameter int PREDICTOR_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vfd_req_if.sink   req_i,
  vfd_smp_if.source smp_o
);

  vfd_pkg::cmd_t cmd;
  vfd_pkg::sts_t sts;
  logic          req_ready;

  assign req_i.ready = req_ready;

  vfd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  vfd_datapath #(
    .PREDICTOR_COUNT (PREDICTOR_COUNT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .book_address_i     (req_i.book_address),
    .book_value_i       (req_i.book_value),
    .history_older_i    (req_i.history_older),
    .history_newer_i    (req_i.history_newer),
    .scale_i            (req_i.scale),
    .predictor_select_i (req_i.predictor_select),
    .frame_data_i       (req_i.frame_data),
    .smp_ready_i        (smp_o.ready),
    .smp_valid_o        (smp_o.valid),
    .smp_sample_o       (smp_o.sample),
    .smp_last_o         (smp_o.last)
  );

endmodule

// ===== sv/vfd_ctrl.sv =====
// Sequencer for the VADPCM frame decoder: request decode, codebook fetch,
// multiply-accumulate steps and sample hand-off. Uses vfd_pkg and the assert header.
`include "vadpcm_frame_decoder_top_assert.svh"

module vfd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic [1:0]    req_opcode_i,
  output logic          req_ready_o,
  input  vfd_pkg::sts_t sts_i,
  output vfd_pkg::cmd_t cmd_o
);

  vfd_pkg::state_e state_q, state_d;
  logic [4:0] ld_q, ld_d;   // codebook fetch counter, counts to TAPS
  logic [3:0] k_q, k_d;     // sample index in frame
  logic [3:0] t_q, t_d;     // step within one sample
  logic [2:0] i_pos;        // sample index in half
  logic [3:0] t_end;

  assign i_pos = k_q[2:0];
  assign t_end = 4'(i_pos) + 4'd1;

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vfd_pkg::ST_IDLE;
      ld_q    <= '0;
      k_q     <= '0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      ld_q    <= ld_d;
      k_q     <= k_d;
      t_q     <= t_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    ld_d        = ld_q;
    k_d         = k_q;
    t_d         = t_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      vfd_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          unique case (vfd_pkg::op_e'(req_opcode_i))
            vfd_pkg::OP_BOOK_WR:  cmd_o.book_wr = 1'b1;
            vfd_pkg::OP_HIST_SET: cmd_o.hist_set = 1'b1;
            vfd_pkg::OP_DECODE: begin
              cmd_o.frame_cap = 1'b1;
              ld_d            = '0;
              state_d         = vfd_pkg::ST_LOAD;
            end
            default: ;  // drop unknown opcode
          endcase
        end
      end
      vfd_pkg::ST_LOAD: begin
        // fetch one word, store the previous one into the coefficient file
        if (ld_q != 5'(vfd_pkg::TAPS)) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_tap = ld_q[3:0];
        end
        if (ld_q != '0) begin
          cmd_o.coef_wr     = 1'b1;
          cmd_o.coef_wr_idx = 4'(ld_q - 5'd1);
        end
        if (ld_q == 5'(vfd_pkg::TAPS)) begin
          state_d = vfd_pkg::ST_MAC;
          k_d     = '0;
          t_d     = '0;
        end else begin
          ld_d = ld_q + 5'd1;
        end
      end
      vfd_pkg::ST_MAC: begin
        cmd_o.mac_en    = 1'b1;
        cmd_o.acc_first = (t_q == '0);
        if (t_q == 4'd0) begin
          cmd_o.opnd     = vfd_pkg::OPND_OLD;
          cmd_o.coef_idx = {1'b0, i_pos};
          cmd_o.res_idx  = k_q;
        end else if (t_q == 4'd1) begin
          cmd_o.opnd     = vfd_pkg::OPND_NEW;
          cmd_o.coef_idx = {1'b1, i_pos};
          cmd_o.res_idx  = k_q;
        end else begin
          // earlier residual of this half times a c2 tap
          cmd_o.opnd     = vfd_pkg::OPND_RES;
          cmd_o.coef_idx = {1'b1, 3'(t_q - 4'd2)};
          cmd_o.res_idx  = k_q + 4'd1 - t_q;
        end
        if (t_q == t_end) begin
          state_d = vfd_pkg::ST_EMIT;
        end else begin
          t_d = t_q + 4'd1;
        end
      end
      vfd_pkg::ST_EMIT: begin
        // hold until the output register can take the sample
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.last     = (k_q == 4'd15);
          cmd_o.save_s6  = (i_pos == 3'd6);
          cmd_o.hist_upd = (i_pos == 3'd7);
          if (k_q == 4'd15) begin
            state_d = vfd_pkg::ST_IDLE;
          end else begin
            k_d     = k_q + 4'd1;
            t_d     = '0;
            state_d = vfd_pkg::ST_MAC;
          end
        end
      end
      default: state_d = vfd_pkg::ST_IDLE;
    endcase
  end

  `VFD_ASSERT(a_step_bound, (state_q == vfd_pkg::ST_MAC) |-> (t_q <= t_end), "MAC step overrun")
  `VFD_ASSERT(a_last_idle, (cmd_o.emit && cmd_o.last) |=> (state_q == vfd_pkg::ST_IDLE), "frame end without idle")
  `VFD_ASSERT_ALWAYS(a_load_only_decode, (state_q == vfd_pkg::ST_LOAD) |-> !req_ready_o, "request taken during fetch")

endmodule

// ===== sv/vfd_datapath.sv =====
// Datapath of the VADPCM frame decoder: codebook memory, coefficient file,
// residual unpack, multiply-accumulate, saturation, history and output register.
// Uses vfd_pkg and the assert header.
`include "vadpcm_frame_decoder_top_assert.svh"

module vfd_datapath #(
  parameter int PREDICTOR_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vfd_pkg::cmd_t      cmd_i,
  output vfd_pkg::sts_t      sts_o,
  input  logic        [7:0]  book_address_i,
  input  logic signed [15:0] book_value_i,
  input  logic signed [15:0] history_older_i,
  input  logic signed [15:0] history_newer_i,
  input  logic        [3:0]  scale_i,
  input  logic        [3:0]  predictor_select_i,
  input  logic        [63:0] frame_data_i,
  input  logic               smp_ready_i,
  output logic               smp_valid_o,
  output logic signed [15:0] smp_sample_o,
  output logic               smp_last_o
);

  localparam int BOOK_WORDS = PREDICTOR_COUNT * vfd_pkg::TAPS;
  localparam int AW         = $clog2(BOOK_WORDS);

  logic signed [15:0] book_mem [BOOK_WORDS];
  logic signed [15:0] rdata_q;
  logic signed [15:0] coef_q [vfd_pkg::TAPS];
  logic        [3:0]  sel_q, sel_sat;
  logic        [63:0] frame_q;
  logic        [3:0]  scale_q;
  logic signed [15:0] hold_q, hnew_q, s6_q;
  logic        [31:0] acc_q, acc_d, acc_base;
  logic               out_valid_q, out_last_q;
  logic signed [15:0] out_sample_q;

  logic               addr_ok;
  logic [AW-1:0]      rd_addr;
  logic        [3:0]  nib;
  logic        [15:0] nib_ext;
  logic signed [15:0] res;
  logic signed [15:0] coef_rd;
  logic signed [15:0] opnd;
  logic signed [31:0] prod;
  logic signed [15:0] sat;
  logic               sat_pos, sat_neg;

  // Codebook port: writes from requests, reads during the fetch
  assign addr_ok = {1'b0, book_address_i} < 9'(BOOK_WORDS);
  assign rd_addr = AW'({sel_q, cmd_i.rd_tap});

  always_ff @(posedge clk_i) begin
    if (cmd_i.book_wr && addr_ok) begin
      book_mem[book_address_i[AW-1:0]] <= book_value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= book_mem[rd_addr];
    end
  end

  // Coefficient file for the selected predictor
  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr) begin
      coef_q[cmd_i.coef_wr_idx] <= rdata_q;
    end
  end

  // Clamp the predictor select to the last predictor
  assign sel_sat = ({1'b0, predictor_select_i} > 5'(PREDICTOR_COUNT - 1)) ?
                   4'(PREDICTOR_COUNT - 1) : predictor_select_i;

  // Frame capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_cap) begin
      frame_q <= frame_data_i;
      scale_q <= scale_i;
      sel_q   <= sel_sat;
    end
  end

  // Residual: signed nibble shifted by scale, low 16 bits kept
  assign nib     = frame_q[{~cmd_i.res_idx, 2'b00} +: 4];
  assign nib_ext = {{12{nib[3]}}, nib};
  assign res     = nib_ext << scale_q;

  // Multiply-accumulate, 32-bit wrapping
  assign coef_rd = coef_q[cmd_i.coef_idx];

  always_comb begin
    case (cmd_i.opnd)
      vfd_pkg::OPND_OLD: opnd = hold_q;
      vfd_pkg::OPND_NEW: opnd = hnew_q;
      default:           opnd = res;
    endcase
  end

  assign prod     = coef_rd * opnd;
  assign acc_base = cmd_i.acc_first ?
                    {{5{res[15]}}, res, {vfd_pkg::FRAC_BITS{1'b0}}} : acc_q;
  assign acc_d    = acc_base + prod;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      acc_q <= acc_d;
    end
  end

  // Arithmetic shift by the fraction bits, then saturate to 16 bits
  assign sat_pos = !acc_q[31] && (acc_q[30:26] != '0);
  assign sat_neg = acc_q[31] && (acc_q[30:26] != '1);

  always_comb begin
    if (sat_pos) begin
      sat = 16'sh7fff;
    end else if (sat_neg) begin
      sat = -16'sh8000;
    end else begin
      sat = acc_q[26:11];
    end
  end

  // History
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      hnew_q <= '0;
    end else if (cmd_i.hist_set) begin
      hold_q <= history_older_i;
      hnew_q <= history_newer_i;
    end else if (cmd_i.hist_upd) begin
      hold_q <= s6_q;
      hnew_q <= sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_s6) begin
      s6_q <= sat;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (smp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_sample_q <= sat;
      out_last_q   <= cmd_i.last;
    end
  end

  assign sts_o.out_free = !out_valid_q || smp_ready_i;
  assign smp_valid_o    = out_valid_q;
  assign smp_sample_o   = out_sample_q;
  assign smp_last_o     = out_last_q;

  `VFD_ASSERT(a_emit_free, cmd_i.emit |-> sts_o.out_free, "sample emitted over a pending one")
  `VFD_ASSERT(a_hist_follows, cmd_i.hist_upd |=> (hnew_q == out_sample_q), "history not taken from last sample")

endmodule

// ===== bench/tb_vadpcm_frame_decoder_top.sv =====
// Self-checking bench for the VADPCM frame decoder: a directed opening, then random requests.
// Depends on vfd_pkg, vfd_if and vadpcm_frame_decoder_top; checks every sample against a
// local second-order predictor that keeps its own codebook and history.
module tb_vadpcm_frame_decoder_top;

  localparam int PRED_COUNT     = 16;
  localparam int BOOK_WORDS     = PRED_COUNT * vfd_pkg::TAPS;
  localparam int RANDOM_ITEMS   = 200;
  localparam int IDLE_LIMIT     = 4000;
  localparam int TAIL_CYCLES    = 150;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Directed coefficients: c1 taps first, then c2 taps
  localparam logic [255:0] DIR_TAPS = {
    16'h7fff, 16'h8000, 16'h1000, 16'hf800, 16'h0400, 16'h0000, 16'hffff, 16'h0001,
    16'h0800, 16'hf000, 16'h7fff, 16'h8000, 16'h0200, 16'hfe00, 16'h0000, 16'h0001
  };

  typedef struct {
    logic        [1:0]  opcode;
    logic        [7:0]  book_address;
    logic signed [15:0] book_value;
    logic signed [15:0] history_older;
    logic signed [15:0] history_newer;
    logic        [3:0]  scale;
    logic        [3:0]  predictor_select;
    logic        [63:0] frame_data;
    bit                 drain_first;
  } vfd_req_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
  } pcm_sample_t;

  logic clk_i;
  logic rst_n;

  vfd_req_if req_if ();
  vfd_smp_if smp_if ();

  vadpcm_frame_decoder_top #(
    .PREDICTOR_COUNT(PRED_COUNT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_n),
    .req_i (req_if),
    .smp_o (smp_if)
  );

  // Predictor state: codebook copy and history
  logic signed [15:0] coef_book [BOOK_WORDS];
  logic signed [15:0] hist_older;
  logic signed [15:0] hist_newer;

  vfd_req_t    request_q[$];
  pcm_sample_t pcm_expected_q[$];
  vfd_req_t    shown_req;

  int total_reqs;
  int reqs_accepted;
  int frames_decoded;
  int book_writes;
  int hist_loads;
  int ignored_reqs;
  int samples_checked;
  int fail_count;
  int idle_cycles;
  int burst_left;
  int gap_left;
  int stall_mode;
  logic [31:0] ready_tick;

  // Generation-time record of which codebook words have been written
  logic [BOOK_WORDS-1:0] gen_written;

  function automatic logic signed [31:0] mul16(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [31:0] wa;
    logic signed [31:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Decode one frame against the local codebook and push its sixteen samples
  function automatic void predict_frame(input logic [3:0] scale, input logic [3:0] sel,
                                        input logic [63:0] frame);
    int                 base;
    int                 k;
    logic [3:0]         nib;
    logic [31:0]        widened;
    logic signed [15:0] res [vfd_pkg::HALF_LEN];
    logic signed [15:0] pcm [vfd_pkg::HALF_LEN];
    logic signed [31:0] acc;
    pcm_sample_t        exp_s;
    base = ((sel >= PRED_COUNT) ? PRED_COUNT - 1 : sel) * vfd_pkg::TAPS;
    for (int half = 0; half < 2; half++) begin
      // Sign-extend each nibble, shift by the scale, keep the low 16 bits
      for (int i = 0; i < vfd_pkg::HALF_LEN; i++) begin
        k = half * vfd_pkg::HALF_LEN + i;
        nib = frame[63 - 4 * k -: 4];
        widened = {{28{nib[3]}}, nib} << scale;
        res[i] = widened[15:0];
      end
      for (int i = 0; i < vfd_pkg::HALF_LEN; i++) begin
        acc = mul16(coef_book[base + i], hist_older)
            + mul16(coef_book[base + vfd_pkg::HALF_LEN + i], hist_newer);
        for (int x = 0; x < i; x++)
          acc = acc + mul16(res[i - 1 - x], coef_book[base + vfd_pkg::HALF_LEN + x]);
        acc = acc + mul16(res[i], 16'sd2048);
        acc = acc >>> vfd_pkg::FRAC_BITS;
        if (acc > 32767) begin
          pcm[i] = 16'sh7fff;
        end else if (acc < -32768) begin
          pcm[i] = 16'sh8000;
        end else begin
          pcm[i] = acc[15:0];
        end
        exp_s.sample = pcm[i];
        exp_s.last   = (half == 1) && (i == vfd_pkg::HALF_LEN - 1);
        pcm_expected_q.push_back(exp_s);
      end
      hist_older = pcm[vfd_pkg::HALF_LEN - 2];
      hist_newer = pcm[vfd_pkg::HALF_LEN - 1];
    end
  endfunction

  // Update the local state for one accepted request
  function automatic void apply_request(input vfd_req_t r);
    case (r.opcode)
      vfd_pkg::OP_BOOK_WR: begin
        if (r.book_address < BOOK_WORDS) coef_book[r.book_address] = r.book_value;
        book_writes++;
      end
      vfd_pkg::OP_HIST_SET: begin
        hist_older = r.history_older;
        hist_newer = r.history_newer;
        hist_loads++;
      end
      vfd_pkg::OP_DECODE: begin
        predict_frame(r.scale, r.predictor_select, r.frame_data);
        frames_decoded++;
      end
      default: ignored_reqs++;
    endcase
  endfunction

  function automatic logic signed [15:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, 8191)) - 16'sd4096;
    endcase
  endfunction

  function automatic logic [63:0] random_frame();
    case ($urandom_range(0, 19))
      0:       return {16{4'h8}};
      1:       return {16{4'h7}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Fill every field at random so that unused fields carry noise too
  function automatic vfd_req_t random_req(input logic [1:0] op);
    vfd_req_t r;
    r.opcode           = op;
    r.book_address     = 8'($urandom);
    r.book_value       = 16'($urandom);
    r.history_older    = 16'($urandom);
    r.history_newer    = 16'($urandom);
    r.scale            = 4'($urandom);
    r.predictor_select = 4'($urandom);
    r.frame_data       = {$urandom, $urandom};
    r.drain_first      = ($urandom_range(0, 29) == 0);
    return r;
  endfunction

  task automatic push_book_write(input int addr, input logic signed [15:0] value);
    vfd_req_t r;
    r = random_req(vfd_pkg::OP_BOOK_WR);
    r.book_address = 8'(addr);
    r.book_value   = value;
    if (addr < BOOK_WORDS) gen_written[addr] = 1'b1;
    request_q.push_back(r);
  endtask

  task automatic push_history(input logic signed [15:0] older, input logic signed [15:0] newer);
    vfd_req_t r;
    r = random_req(vfd_pkg::OP_HIST_SET);
    r.history_older = older;
    r.history_newer = newer;
    request_q.push_back(r);
  endtask

  task automatic push_decode(input logic [3:0] scale, input logic [3:0] sel,
                             input logic [63:0] frame, input bit drain);
    vfd_req_t r;
    r = random_req(vfd_pkg::OP_DECODE);
    r.scale            = scale;
    r.predictor_select = sel;
    r.frame_data       = frame;
    r.drain_first      = r.drain_first | drain;
    request_q.push_back(r);
  endtask

  // Clock, and known values on every input from time zero
  initial begin
    clk_i = 1'b0;
    rst_n = 1'b0;
    req_if.valid            = 1'b0;
    req_if.opcode           = '0;
    req_if.book_address     = '0;
    req_if.book_value       = '0;
    req_if.history_older    = '0;
    req_if.history_newer    = '0;
    req_if.scale            = '0;
    req_if.predictor_select = '0;
    req_if.frame_data       = '0;
    smp_if.ready            = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Request driver: bursts and gaps, optional hold until all samples are back
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      burst_left = $urandom_range(1, 10);
      gap_left   = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_request(shown_req);
        reqs_accepted++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].drain_first && pcm_expected_q.size() != 0)) begin
          shown_req = request_q.pop_front();
          req_if.valid            <= 1'b1;
          req_if.opcode           <= shown_req.opcode;
          req_if.book_address     <= shown_req.book_address;
          req_if.book_value       <= shown_req.book_value;
          req_if.history_older    <= shown_req.history_older;
          req_if.history_newer    <= shown_req.history_newer;
          req_if.scale            <= shown_req.scale;
          req_if.predictor_select <= shown_req.predictor_select;
          req_if.frame_data       <= shown_req.frame_data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Sample monitor: check each accepted sample, then pick the next ready
  always @(posedge clk_i or negedge rst_n) begin
    pcm_sample_t exp_s;
    logic        nxt_ready;
    if (!rst_n) begin
      smp_if.ready <= 1'b0;
      ready_tick = '0;
      stall_mode = 0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        samples_checked++;
        if (pcm_expected_q.size() == 0) begin
          $error("sample with no expectation pending: sample %0d last %0b",
                 smp_if.sample, smp_if.last);
          fail_count++;
        end else begin
          exp_s = pcm_expected_q.pop_front();
          if (smp_if.sample !== exp_s.sample) begin
            $error("sample mismatch: expected %0d, actual %0d", exp_s.sample, smp_if.sample);
            fail_count++;
          end
          if (smp_if.last !== exp_s.last) begin
            $error("last mismatch: expected %0b, actual %0b", exp_s.last, smp_if.last);
            fail_count++;
          end
        end
      end
      // Periodically draw a new stall pattern at random, then set the next ready from it
      ready_tick = ready_tick + 1;
      if (ready_tick % 48 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       nxt_ready = 1'b1;
        1:       nxt_ready = 1'($urandom_range(0, 1));
        2:       nxt_ready = (ready_tick % 4 == 0);
        default: nxt_ready = ready_tick[3];
      endcase
      smp_if.ready <= nxt_ready;
    end
  end

  // Count cycles with no request and no sample moving
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (smp_if.valid && smp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int       random_items;
    int       sel_pick;
    int       pred;
    int       ready_list[$];
    vfd_req_t noise;
    hist_older      = '0;
    hist_newer      = '0;
    gen_written     = '0;
    reqs_accepted   = 0;
    frames_decoded  = 0;
    book_writes     = 0;
    hist_loads      = 0;
    ignored_reqs    = 0;
    samples_checked = 0;
    fail_count      = 0;
    for (int a = 0; a < BOOK_WORDS; a++) coef_book[a] = '0;

    // Directed: load the last predictor with extreme taps, decode from zero history
    for (int t = 0; t < vfd_pkg::TAPS; t++)
      push_book_write((PRED_COUNT - 1) * vfd_pkg::TAPS + t, DIR_TAPS[255 - 16 * t -: 16]);
    push_decode(4'd0, 4'hf, 64'h0123_4567_89ab_cdef, 1'b0);
    push_history(16'sh7fff, 16'sh8000);
    push_decode(4'd15, 4'hf, {16{4'h8}}, 1'b0);
    push_decode(4'd11, 4'hf, {16{4'h7}}, 1'b0);
    noise = random_req(OP_RESERVED);
    request_q.push_back(noise);
    push_history(16'sh8000, 16'sh7fff);
    push_decode(4'd12, 4'hf, {16{4'hf}}, 1'b1);
    push_decode(4'd4, 4'hf, 64'h0, 1'b0);

    // Random: mostly decodes from fully loaded predictors, with loads and noise
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 99)) inside
        [0:49]: begin
          ready_list.delete();
          for (int p = 0; p < PRED_COUNT; p++)
            if (&gen_written[p * vfd_pkg::TAPS +: vfd_pkg::TAPS]) ready_list.push_back(p);
          sel_pick = ready_list[$urandom_range(0, ready_list.size() - 1)];
          if (sel_pick == PRED_COUNT - 1) sel_pick = $urandom_range(sel_pick, 15);
          push_decode(4'($urandom), 4'(sel_pick), random_frame(), 1'b0);
          random_items++;
        end
        [50:59]: begin
          pred = $urandom_range(0, PRED_COUNT - 1);
          for (int t = 0; t < vfd_pkg::TAPS; t++)
            push_book_write(pred * vfd_pkg::TAPS + t, random_word());
          random_items += vfd_pkg::TAPS;
        end
        [60:74]: begin
          push_book_write($urandom_range(0, 255), random_word());
          random_items++;
        end
        [75:89]: begin
          push_history(random_word(), random_word());
          random_items++;
        end
        default: begin
          noise = random_req(OP_RESERVED);
          request_q.push_back(noise);
        end
      endcase
    end
    total_reqs = request_q.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Wait for every request, then every sample, then let the block settle
    while (reqs_accepted < total_reqs) @(posedge clk_i);
    while (pcm_expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d frame decodes with %0d samples checked, %0d codebook writes,",
             frames_decoded, samples_checked, book_writes);
    $display("%0d history loads and %0d reserved-opcode requests.", hist_loads, ignored_reqs);
    if (fail_count == 0 && pcm_expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
